// ===== src/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file in src uses this package.
`default_nettype none

package spq_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CountW  = 5;
  localparam int unsigned Depth   = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Broadcast from the control logic to every cell of the chain.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DataW-1:0]  value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/spq_if.sv =====
// Request and response channel interfaces of the sorted priority queue.
// Depends on spq_pkg for field widths and codes.
`default_nettype none

interface spq_req_if;
  logic                               valid;
  logic                               ready;
  spq_pkg::op_e                       opcode;
  logic signed [spq_pkg::DataW-1:0]   value;

  modport source (output valid, opcode, value, input ready);
  modport sink   (input valid, opcode, value, output ready);
endinterface

interface spq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [spq_pkg::DataW-1:0]   removed_value;
  logic                               removed_valid;
  spq_pkg::status_e                   status;
  logic [spq_pkg::CountW-1:0]         count;
  logic                               is_empty;
  logic                               is_full;

  modport source (output valid, removed_value, removed_valid, status, count, is_empty,
                  is_full, input ready);
  modport sink   (input valid, removed_value, removed_valid, status, count, is_empty,
                  is_full, output ready);
endinterface

`default_nettype wire

// ===== src/spq_cell.sv =====
// One slot of the sorted chain: holds a value, keeps it, takes the new
// value or shifts in a neighbor's value. Depends on spq_pkg.
`default_nettype none

module spq_cell (
  input  logic                               clk_i,
  input  spq_pkg::cell_ctrl_t                ctrl_i,
  input  logic                               occ_i,
  input  logic                               prev_keep_i,
  input  logic signed [spq_pkg::DataW-1:0]   prev_data_i,
  input  logic signed [spq_pkg::DataW-1:0]   next_data_i,
  output logic                               keep_o,
  output logic signed [spq_pkg::DataW-1:0]   data_o
);

  logic signed [spq_pkg::DataW-1:0] data_q, data_d;

  // Hold while the stored value is at least the new one; equal values stay ahead.
  assign keep_o = occ_i && !(data_q < ctrl_i.value);
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (!keep_o) begin
        data_d = prev_keep_i ? ctrl_i.value : prev_data_i;
      end
    end else if (ctrl_i.rem) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

`default_nettype wire

// ===== src/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: a chain of spq_cell slots plus
// count and response logic. Depends on spq_pkg, spq_if and spq_cell.
`default_nettype none

// Holds up to DEPTH signed 32-bit values sorted largest first in a chain of
// cells; every cell compares against the new value in parallel and shifts
// one place toward its neighbor, so each request updates the chain and the registered response together, and a
// new request is taken every cycle while the response register drains. Each
// request gives exactly one response: a remove returns the largest value,
// an insert into a full queue or a remove from an empty queue is refused
// with an error status and leaves the contents unchanged. The count field
// reports the low five bits of the stored count.
module sorted_priority_queue_top #(
  parameter int unsigned DEPTH = spq_pkg::Depth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  spq_req_if.sink       req_i,
  spq_rsp_if.source     rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            full, empty, accept, ins_ok, rem_ok;

  logic signed [spq_pkg::DataW-1:0] data [DEPTH];
  logic                             keep [DEPTH];
  logic                             occ  [DEPTH];
  spq_pkg::cell_ctrl_t              ctrl;

  logic                             rsp_valid_q;
  logic signed [spq_pkg::DataW-1:0] rsp_value_q, rsp_value_d;
  logic                             rsp_rvalid_q, rsp_rvalid_d;
  spq_pkg::status_e                 rsp_status_q, rsp_status_d;
  logic [CntW-1:0]                  rsp_count_q;

  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept = req_i.valid && req_i.ready;
  assign ins_ok = accept && (req_i.opcode == spq_pkg::OP_INSERT) && !full;
  assign rem_ok = accept && (req_i.opcode == spq_pkg::OP_REMOVE) && !empty;

  assign ctrl.ins   = ins_ok;
  assign ctrl.rem   = rem_ok;
  assign ctrl.value = req_i.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                             prev_keep;
    logic signed [spq_pkg::DataW-1:0] prev_data, next_data;

    assign occ[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
      assign prev_data = req_i.value;
    end else begin : g_body
      assign prev_keep = keep[i-1];
      assign prev_data = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_data = data[i];
    end else begin : g_inner
      assign next_data = data[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ[i]),
      .prev_keep_i (prev_keep),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .keep_o      (keep[i]),
      .data_o      (data[i])
    );
  end

  always_comb begin
    count_d      = count_q;
    rsp_value_d  = '0;
    rsp_rvalid_d = 1'b0;
    rsp_status_d = spq_pkg::ST_OK;
    if (req_i.opcode == spq_pkg::OP_INSERT) begin
      if (full) begin
        rsp_status_d = spq_pkg::ST_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        rsp_status_d = spq_pkg::ST_EMPTY;
      end else begin
        count_d      = count_q - CntW'(1);
        rsp_value_d  = data[0];
        rsp_rvalid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_value_q  <= rsp_value_d;
      rsp_rvalid_q <= rsp_rvalid_d;
      rsp_status_q <= rsp_status_d;
      rsp_count_q  <= count_d;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.removed_value = rsp_value_q;
  assign rsp_o.removed_valid = rsp_rvalid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.count         = spq_pkg::CountW'(rsp_count_q);
  assign rsp_o.is_empty      = (rsp_count_q == '0);
  assign rsp_o.is_full       = (rsp_count_q == CntW'(DEPTH));

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("stored count exceeds depth");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> !(data[0] < data[1]))
    else $error("head of chain is out of order");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_ok |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not advance the count");

  a_remove_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_rvalid_q) |-> (rsp_status_q == spq_pkg::ST_OK))
    else $error("removed value reported with error status");

endmodule

`default_nettype wire

// ===== sim/tb_sorted_priority_queue_top.sv =====
// Self-checking testbench for sorted_priority_queue_top: drives insert and remove requests,
// predicts every response from a sorted shadow queue and compares field by field.
// Depends on spq_pkg, spq_if and the RTL under src.
`timescale 1ns / 100ps

module tb_sorted_priority_queue_top;

  localparam int DEPTH        = spq_pkg::Depth;
  localparam int HOLD_CYCLES  = 80;
  localparam int STUCK_LIMIT  = 1000;
  localparam int PHASE_ITEMS  = 200;

  typedef struct {
    logic signed [spq_pkg::DataW-1:0] removed_value;
    logic                             removed_valid;
    spq_pkg::status_e                 status;
    logic [spq_pkg::CountW-1:0]       count;
    logic                             is_empty;
    logic                             is_full;
  } spq_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  spq_req_if req_bus ();
  spq_rsp_if rsp_bus ();

  sorted_priority_queue_top #(.DEPTH(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow contents, largest first, and the responses still owed by the block.
  logic signed [spq_pkg::DataW-1:0] shadow_q[$];
  spq_result_t                      pending_rsp_q[$];

  int send_idle_pct = 29;
  int recv_idle_pct = 51;
  bit hold_request  = 1'b0;
  int hold_left     = 0;
  int stuck_cycles  = 0;

  int mismatch_count = 0;
  int rsp_checked    = 0;
  int n_inserts      = 0;
  int n_removes      = 0;
  int n_full_refused = 0;
  int n_empty_refused = 0;
  int peak_count     = 0;

  function automatic spq_result_t predict_request(spq_pkg::op_e op,
                                                  logic signed [spq_pkg::DataW-1:0] v);
    spq_result_t r;
    int pos;
    int n;
    r.removed_value = '0;
    r.removed_valid = 1'b0;
    r.status        = spq_pkg::ST_OK;
    if (op == spq_pkg::OP_INSERT) begin
      if (shadow_q.size() >= DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // Land behind every stored value that is not smaller.
        pos = 0;
        while (pos < shadow_q.size() && shadow_q[pos] >= v) pos++;
        shadow_q.insert(pos, v);
      end
    end else if (shadow_q.size() == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.removed_value = shadow_q.pop_front();
      r.removed_valid = 1'b1;
    end
    n          = shadow_q.size();
    r.count    = n[spq_pkg::CountW-1:0];
    r.is_empty = (n == 0);
    r.is_full  = (n == DEPTH);
    return r;
  endfunction

  function automatic logic signed [spq_pkg::DataW-1:0] rand_value();
    logic signed [spq_pkg::DataW-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = $urandom;
      5, 6, 7:       v = $signed($urandom_range(8)) - 4;
      8:             v = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default:       v = $urandom_range(1) ? 32'sh7FFF_FFFF - $urandom_range(3)
                                           : 32'sh8000_0000 + $urandom_range(3);
    endcase
    return v;
  endfunction

  task automatic send_request(input spq_pkg::op_e op,
                              input logic signed [spq_pkg::DataW-1:0] v);
    spq_result_t r;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid  <= 1'b1;
    req_bus.opcode <= op;
    req_bus.value  <= v;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    r = predict_request(op, v);
    pending_rsp_q.push_back(r);
    if (op == spq_pkg::OP_INSERT) n_inserts++;
    else n_removes++;
    if (r.status == spq_pkg::ST_FULL) n_full_refused++;
    if (r.status == spq_pkg::ST_EMPTY) n_empty_refused++;
    if (shadow_q.size() > peak_count) peak_count = shadow_q.size();
  endtask

  task automatic wait_drain();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_extremes();
    send_request(spq_pkg::OP_REMOVE, 32'sh1234_5678);
    send_request(spq_pkg::OP_INSERT, 32'sh7FFF_FFFF);
    send_request(spq_pkg::OP_INSERT, 32'sh8000_0000);
    send_request(spq_pkg::OP_INSERT, 32'sd0);
    send_request(spq_pkg::OP_INSERT, -32'sd1);
    send_request(spq_pkg::OP_INSERT, 32'sd1);
    send_request(spq_pkg::OP_INSERT, 32'sh7FFF_FFFF);
    send_request(spq_pkg::OP_INSERT, 32'sh8000_0000);
    send_request(spq_pkg::OP_REMOVE, 32'shFFFF_FFFF);
    send_request(spq_pkg::OP_REMOVE, 32'sd0);
    wait_drain();
  endtask

  task automatic test_fill_to_full();
    while (shadow_q.size() < DEPTH) send_request(spq_pkg::OP_INSERT, rand_value());
    send_request(spq_pkg::OP_INSERT, 32'sh5A5A_A5A5);
    send_request(spq_pkg::OP_REMOVE, 32'sd0);
    wait_drain();
  endtask

  // Mix insert-heavy, remove-heavy and balanced bursts in random order so the queue swings between
  // empty and full and both refusals recur.
  task automatic test_random_traffic(input int s_pct, input int r_pct, input int n_items);
    int sent;
    int burst;
    int ins_pct;
    spq_pkg::op_e op;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(10, 40);
      case ($urandom_range(2))
        0:       ins_pct = 85;
        1:       ins_pct = 15;
        default: ins_pct = 50;
      endcase
      repeat (burst) begin
        op = ($urandom_range(99) < ins_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
        send_request(op, rand_value());
        sent++;
      end
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    spq_pkg::op_e op;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    repeat (30) begin
      op = ($urandom_range(99) < 70) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
      send_request(op, rand_value());
    end
    wait_drain();
  endtask

  // Response checker and receiver ready.
  always @(posedge clk_i) begin
    spq_result_t e;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      rsp_checked++;
      if (pending_rsp_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected response: value=%0d valid=%0b status=%0d count=%0d",
                   rsp_bus.removed_value, rsp_bus.removed_valid, rsp_bus.status,
                   rsp_bus.count);
      end else begin
        e = pending_rsp_q.pop_front();
        if (rsp_bus.removed_value !== e.removed_value ||
            rsp_bus.removed_valid !== e.removed_valid ||
            rsp_bus.status !== e.status || rsp_bus.count !== e.count ||
            rsp_bus.is_empty !== e.is_empty || rsp_bus.is_full !== e.is_full) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch on response %0d: expected value=%0d valid=%0b status=%0d",
                     rsp_checked, e.removed_value, e.removed_valid, e.status);
            $display("  count=%0d empty=%0b full=%0b; got value=%0d valid=%0b status=%0d",
                     e.count, e.is_empty, e.is_full, rsp_bus.removed_value,
                     rsp_bus.removed_valid, rsp_bus.status);
            $display("  count=%0d empty=%0b full=%0b",
                     rsp_bus.count, rsp_bus.is_empty, rsp_bus.is_full);
          end
        end
      end
    end
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: nothing moved on either channel for %0d cycles", STUCK_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    req_bus.valid  = 1'b0;
    req_bus.opcode = spq_pkg::OP_INSERT;
    req_bus.value  = '0;
    rsp_bus.ready  = 1'b0;
    rst_ni         = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_fill_to_full();
    test_random_traffic(29, 51, PHASE_ITEMS);
    test_random_traffic(51, 29, PHASE_ITEMS);
    test_backpressure();
    test_random_traffic(0, 0, PHASE_ITEMS);

    repeat (5) @(posedge clk_i);
    if (pending_rsp_q.size() != 0) mismatch_count++;
    $display("Sent %0d inserts and %0d removes; %0d refused as full, %0d as empty; peak %0d/%0d.",
             n_inserts, n_removes, n_full_refused, n_empty_refused, peak_count, DEPTH);
    $display("Checked %0d responses over three idle mixes and a long receiver stall.",
             rsp_checked);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
